// ===== hw/rtl/sbcd_pkg.sv =====
// Shared types, codes and constants for the SCSI block command decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbcd_pkg;

  localparam int unsigned REPLY_BYTES = 36;
  localparam int unsigned EMIT_CAP    = 36;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CMD   = 2'd1;
  localparam logic [1:0] ST_BAD_FIELD = 2'd2;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_READ  = 2'd1;
  localparam logic [1:0] DIR_WRITE = 2'd2;

  localparam logic [2:0] REG_BLK_BYTES   = 3'd0;
  localparam logic [2:0] REG_BLOCK_COUNT = 3'd1;
  localparam logic [2:0] REG_REMOVABLE   = 3'd2;
  localparam logic [2:0] REG_DEVICE_TYPE = 3'd3;
  localparam logic [2:0] REG_VENDOR      = 3'd4;
  localparam logic [2:0] REG_PRODUCT_HI  = 3'd5;
  localparam logic [2:0] REG_PRODUCT_LO  = 3'd6;
  localparam logic [2:0] REG_REVISION    = 3'd7;

  localparam logic [3:0] KEY_ILLEGAL = 4'd5;
  localparam logic [7:0] ASC_BAD_CMD   = 8'h20;
  localparam logic [7:0] ASC_BAD_FIELD = 8'h24;

  // reply kinds
  typedef enum logic [2:0] {
    RK_SENSE, RK_INQ, RK_EVPD, RK_MODE, RK_FMT, RK_CAP
  } reply_kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SAT, S_ONE, S_REPLY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch command and decode
    logic mul;       // capture products
    logic sat;       // saturate results
    logic step;      // advance reply index
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rw_op;     // decoded read or write
    logic reply;     // decoded reply command with bytes to send
    logic final_byte; // current reply byte is the last
  } dp_stat_t;

  typedef struct packed {
    logic [31:0] blk_bytes;
    logic [31:0] block_count;
    logic        removable;
    logic [4:0]  device_type;
    logic [63:0] vendor_id;
    logic [63:0] product_id_high;
    logic [63:0] product_id_low;
    logic [31:0] revision_id;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sbcd_regs.sv =====
// APB configuration registers of the decoder.
// Uses sbcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbcd_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [5:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic      [63:0]   prdata,
  output logic               pready,
  output sbcd_pkg::cfg_t     cfg
);
  logic [2:0] idx;
  logic       wr;
  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  assign pready = 1'b1;

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blk_bytes       <= 32'd512;
      cfg.block_count     <= 32'd36;
      cfg.removable       <= 1'b0;
      cfg.device_type     <= 5'd0;
      cfg.vendor_id       <= 64'd0;
      cfg.product_id_high <= 64'd0;
      cfg.product_id_low  <= 64'd0;
      cfg.revision_id     <= 32'd0;
    end else if (wr) begin
      unique case (idx)
        sbcd_pkg::REG_BLK_BYTES:   cfg.blk_bytes       <= pwdata[31:0];
        sbcd_pkg::REG_BLOCK_COUNT: cfg.block_count     <= pwdata[31:0];
        sbcd_pkg::REG_REMOVABLE:   cfg.removable       <= pwdata[0];
        sbcd_pkg::REG_DEVICE_TYPE: cfg.device_type     <= pwdata[4:0];
        sbcd_pkg::REG_VENDOR:      cfg.vendor_id       <= pwdata;
        sbcd_pkg::REG_PRODUCT_HI:  cfg.product_id_high <= pwdata;
        sbcd_pkg::REG_PRODUCT_LO:  cfg.product_id_low  <= pwdata;
        sbcd_pkg::REG_REVISION:    cfg.revision_id     <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      sbcd_pkg::REG_BLK_BYTES:   prdata = {32'd0, cfg.blk_bytes};
      sbcd_pkg::REG_BLOCK_COUNT: prdata = {32'd0, cfg.block_count};
      sbcd_pkg::REG_REMOVABLE:   prdata = {63'd0, cfg.removable};
      sbcd_pkg::REG_DEVICE_TYPE: prdata = {59'd0, cfg.device_type};
      sbcd_pkg::REG_VENDOR:      prdata = cfg.vendor_id;
      sbcd_pkg::REG_PRODUCT_HI:  prdata = cfg.product_id_high;
      sbcd_pkg::REG_PRODUCT_LO:  prdata = cfg.product_id_low;
      sbcd_pkg::REG_REVISION:    prdata = {32'd0, cfg.revision_id};
      default:                   prdata = 64'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sbcd_datapath.sv =====
// Decode, multiply, saturation and reply byte generation.
// Uses sbcd_pkg; driven by sbcd_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module sbcd_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  sbcd_pkg::cfg_t         cfg,
  input  wire logic [63:0]       cdb_front,
  input  wire logic [63:0]       cdb_back,
  input  wire logic [31:0]       host_length,
  input  sbcd_pkg::dp_cmd_t      cmd,
  output sbcd_pkg::dp_stat_t     stat,
  output logic [1:0]             status,
  output logic [1:0]             direction,
  output logic [31:0]            transfer_length,
  output logic [63:0]            byte_address,
  output logic                   reply_valid,
  output logic [5:0]             reply_index,
  output logic [7:0]             reply_byte
);
  logic [3:0]  key;
  logic [7:0]  asc;
  logic [7:0]  op;
  logic [4:0]  cm;
  logic        rw;
  logic [63:0] lba;
  logic [31:0] cnt;

  // latched decode
  logic        is_medium, is_reply;
  sbcd_pkg::reply_kind_t kind;
  logic [5:0]  nbytes;
  logic [63:0] lba_r;
  logic [31:0] cnt_r;
  logic [3:0]  key_snap;
  logic [7:0]  asc_snap;

  // decode combinational
  logic [1:0]  d_status, d_dir;
  logic [31:0] d_len;
  logic        d_medium, d_reply, d_fail;
  logic [7:0]  d_asc;
  sbcd_pkg::reply_kind_t d_kind;
  logic [31:0] d_n;

  assign op = cdb_front[63:56];
  assign cm = op[4:0];
  assign rw = (cm == 5'h08) || (cm == 5'h0A);

  always_comb begin
    d_status = sbcd_pkg::ST_OK;
    d_dir    = sbcd_pkg::DIR_NONE;
    d_len    = host_length;
    d_medium = 1'b0;
    d_reply  = 1'b0;
    d_fail   = 1'b0;
    d_asc    = sbcd_pkg::ASC_BAD_CMD;
    d_kind   = sbcd_pkg::RK_MODE;
    lba      = 64'd0;
    cnt      = 32'd0;
    unique case (op[7:5])
      3'd0: begin
        priority case (cm)
          5'h00, 5'h04, 5'h0F, 5'h15, 5'h1B, 5'h1E: ;
          5'h03: begin
            d_reply = 1'b1;
            d_kind  = sbcd_pkg::RK_SENSE;
            d_len   = (cdb_front[31:24] < 8'd18) ? {24'd0, cdb_front[31:24]} : 32'd18;
          end
          5'h08, 5'h0A: begin
            d_medium = 1'b1;
            lba = {48'd0, cdb_front[47:32]};
            cnt = {24'd0, cdb_front[31:24]};
          end
          5'h12: begin
            if (cdb_front[47:40] != 8'd0) begin
              d_fail = 1'b1;
              d_asc  = sbcd_pkg::ASC_BAD_FIELD;
            end else if (cdb_front[48]) begin
              d_reply = 1'b1;
              d_kind  = sbcd_pkg::RK_EVPD;
              d_len   = 32'd5;
            end else begin
              d_reply = 1'b1;
              d_kind  = sbcd_pkg::RK_INQ;
              d_len   = 32'd36;
            end
          end
          5'h1A: begin
            d_reply = 1'b1;
            d_kind  = sbcd_pkg::RK_MODE;
            d_len   = 32'd4;
          end
          default: d_fail = 1'b1;
        endcase
      end
      3'd1: begin
        if (cm == 5'h03) begin
          d_reply = 1'b1;
          d_kind  = sbcd_pkg::RK_FMT;
          d_len   = 32'd12;
        end else if (cm == 5'h05) begin
          d_reply = 1'b1;
          d_kind  = sbcd_pkg::RK_CAP;
        end else if (rw) begin
          d_medium = 1'b1;
          lba = {32'd0, cdb_front[47:16]};
          cnt = {16'd0, cdb_front[7:0], cdb_back[63:56]};
        end else d_fail = 1'b1;
      end
      3'd2: begin
        if (!(cm == 5'h15 || cm == 5'h1A)) d_fail = 1'b1;
      end
      3'd4: begin
        if (rw) begin
          d_medium = 1'b1;
          lba = {cdb_front[47:0], cdb_back[63:48]};
          cnt = cdb_back[47:16];
        end else d_fail = 1'b1;
      end
      3'd5: begin
        if (rw) begin
          d_medium = 1'b1;
          lba = {32'd0, cdb_front[47:16]};
          cnt = {cdb_front[15:0], cdb_back[63:48]};
        end else d_fail = 1'b1;
      end
      default: d_fail = 1'b1;
    endcase
    if (d_fail) begin
      d_status = (d_asc == sbcd_pkg::ASC_BAD_FIELD) ? sbcd_pkg::ST_BAD_FIELD
                                                     : sbcd_pkg::ST_BAD_CMD;
      d_len    = 32'd0;
      d_reply  = 1'b0;
      d_medium = 1'b0;
    end
    if (d_medium) d_dir = (cm == 5'h08) ? sbcd_pkg::DIR_READ : sbcd_pkg::DIR_WRITE;
    d_n = (d_len < 32'(sbcd_pkg::REPLY_BYTES)) ? d_len : 32'(sbcd_pkg::REPLY_BYTES);
    if (d_n > 32'(sbcd_pkg::EMIT_CAP)) d_n = 32'(sbcd_pkg::EMIT_CAP);
  end

  // sense state
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= 4'd0;
      asc <= 8'd0;
    end else if (cmd.load && d_fail) begin
      key <= sbcd_pkg::KEY_ILLEGAL;
      asc <= d_asc;
    end
  end

  // split multiplies: lba * bs as two 32x32 partial products
  logic [63:0] p_lo, p_hi, p_cnt;
  logic [63:0] addr_sum;
  logic        addr_ovf;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status    <= d_status;
      direction <= d_dir;
      transfer_length <= d_len;
      byte_address <= 64'd0;
      is_medium <= d_medium;
      is_reply  <= d_reply && (d_n != 32'd0);
      kind      <= d_kind;
      nbytes    <= d_n[5:0];
      lba_r     <= lba;
      cnt_r     <= cnt;
      key_snap  <= key;
      asc_snap  <= asc;
      reply_index <= 6'd0;
    end
    if (cmd.mul) begin
      p_lo  <= 64'(lba_r[31:0]) * 64'(cfg.blk_bytes);
      p_hi  <= 64'(lba_r[63:32]) * 64'(cfg.blk_bytes);
      p_cnt <= 64'(cnt_r) * 64'(cfg.blk_bytes);
    end
    if (cmd.sat) begin
      byte_address <= addr_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : addr_sum;
      transfer_length <= (p_cnt[63:32] != 32'd0) ? 32'hFFFF_FFFF : p_cnt[31:0];
    end
    if (cmd.step) reply_index <= reply_index + 6'd1;
  end

  logic [32:0] hi_add;
  assign hi_add = {1'b0, p_lo[63:32]} + {1'b0, p_hi[31:0]};
  assign addr_sum = {hi_add[31:0], p_lo[31:0]};
  assign addr_ovf = (p_hi[63:32] != 32'd0) || hi_add[32];

  // reply byte table
  logic [7:0] rb;
  logic [63:0] w64;
  logic [31:0] w32;
  logic [31:0] bcm1;
  assign bcm1 = cfg.block_count - 32'd1;
  always_comb begin
    rb  = 8'd0;
    w64 = 64'd0;
    w32 = 32'd0;
    unique case (kind)
      sbcd_pkg::RK_SENSE: begin
        if (reply_index == 6'd0) rb = 8'h70;
        else if (reply_index == 6'd2) rb = {4'd0, key_snap};
        else if (reply_index == 6'd7) rb = 8'h0A;
        else if (reply_index == 6'd12) rb = asc_snap;
      end
      sbcd_pkg::RK_INQ: begin
        if (reply_index < 6'd8) begin
          if (reply_index == 6'd0) rb = {3'd0, cfg.device_type};
          else if (reply_index == 6'd1) rb = {cfg.removable, 7'd0};
          else if (reply_index == 6'd3) rb = 8'd2;
          else if (reply_index == 6'd4) rb = 8'd31;
        end else if (reply_index < 6'd32) begin
          priority if (reply_index < 6'd16) w64 = cfg.vendor_id;
          else if (reply_index < 6'd24) w64 = cfg.product_id_high;
          else w64 = cfg.product_id_low;
          rb = w64[8'(7 - reply_index[2:0]) * 8 +: 8];
        end else if (reply_index < 6'd36) begin
          rb = cfg.revision_id[8'(3 - reply_index[1:0]) * 8 +: 8];
        end
      end
      sbcd_pkg::RK_EVPD: rb = 8'd0;
      sbcd_pkg::RK_MODE: rb = (reply_index == 6'd0) ? 8'd3 : 8'd0;
      sbcd_pkg::RK_FMT: begin
        if (reply_index == 6'd3) rb = 8'd8;
        else if (reply_index == 6'd8) rb = 8'd2;
        else if (reply_index >= 6'd4 && reply_index < 6'd12) begin
          w32 = (reply_index < 6'd8) ? cfg.block_count : cfg.blk_bytes;
          rb = w32[8'(3 - reply_index[1:0]) * 8 +: 8];
        end
      end
      sbcd_pkg::RK_CAP: begin
        if (reply_index < 6'd8) begin
          w32 = (reply_index < 6'd4) ? bcm1 : cfg.blk_bytes;
          rb = w32[8'(3 - reply_index[1:0]) * 8 +: 8];
        end
      end
      default: rb = 8'd0;
    endcase
  end

  assign reply_valid = is_reply;
  assign reply_byte  = is_reply ? rb : 8'd0;
  assign stat.rw_op  = is_medium;
  assign stat.reply  = is_reply;
  assign stat.final_byte = (reply_index + 6'd1 == nbytes);
endmodule
`default_nettype wire

// ===== hw/rtl/sbcd_ctrl.sv =====
// Sequencer for the decoder: load, multiply, saturate, emit words.
// Uses sbcd_pkg; commands sbcd_datapath.
`timescale 1ns / 1ps
`default_nettype none
module sbcd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                last,
  input  sbcd_pkg::dp_stat_t  stat,
  output sbcd_pkg::dp_cmd_t   cmd
);
  sbcd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= sbcd_pkg::S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sbcd_pkg::S_IDLE: if (in_valid) state_next = sbcd_pkg::S_MUL;
      sbcd_pkg::S_MUL: begin
        if (stat.rw_op) state_next = sbcd_pkg::S_SAT;
        else if (stat.reply) state_next = sbcd_pkg::S_REPLY;
        else state_next = sbcd_pkg::S_ONE;
      end
      sbcd_pkg::S_SAT: state_next = sbcd_pkg::S_ONE;
      sbcd_pkg::S_ONE: if (out_ready) state_next = sbcd_pkg::S_IDLE;
      sbcd_pkg::S_REPLY: if (out_ready && stat.final_byte) state_next = sbcd_pkg::S_IDLE;
      default: state_next = sbcd_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    last      = 1'b0;
    cmd       = '0;
    unique case (state)
      sbcd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sbcd_pkg::S_MUL: cmd.mul = 1'b1;
      sbcd_pkg::S_SAT: cmd.sat = 1'b1;
      sbcd_pkg::S_ONE: begin
        out_valid = 1'b1;
        last = 1'b1;
      end
      sbcd_pkg::S_REPLY: begin
        out_valid = 1'b1;
        last = stat.final_byte;
        cmd.step = out_ready && !stat.final_byte;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while word pending");
  a_load_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> cmd.mul) else $error("load not followed by multiply");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready) else $error("no return to idle");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/scsi_block_command_decoder_unit.sv =====
// The first word is offered after the multiply state for plain and reply
// commands, and after the multiply and saturation states for read/write
// (partial-product multiply, then saturation). One command at a time; a
// reply command emits one word per cycle while out_ready is high, up to 36
// reply bytes; plain and read/write commands emit a single word.
// Reset (rst, synchronous): sense cleared, registers to defaults, idle.
`timescale 1ns / 1ps
`default_nettype none
module scsi_block_command_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] cdb_front,
  input  wire logic [63:0] cdb_back,
  input  wire logic [31:0] host_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [1:0]       direction,
  output logic [31:0]      transfer_length,
  output logic [63:0]      byte_address,
  output logic             reply_valid,
  output logic [5:0]       reply_index,
  output logic [7:0]       reply_byte,
  output logic             last
);
  sbcd_pkg::cfg_t     cfg;
  sbcd_pkg::dp_cmd_t  cmd;
  sbcd_pkg::dp_stat_t stat;
  logic [5:0] ri;

  sbcd_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
                    .prdata, .pready, .cfg);

  sbcd_datapath u_dp (.clk, .rst, .cfg, .cdb_front, .cdb_back, .host_length,
                      .cmd, .stat, .status, .direction, .transfer_length,
                      .byte_address, .reply_valid, .reply_index(ri), .reply_byte);

  assign reply_index = reply_valid ? ri : 6'd0;

  sbcd_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
                    .last, .stat, .cmd);
endmodule
`default_nettype wire
